/* rtl/ssfp_pkg.sv */
// Shared types and constants of the servo status frame parser.
package ssfp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_FIRST_HEADER   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_HEADER  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HIGHEST_ID     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HIGHEST_STATUS = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LONGEST_LENGTH = 3'd4;

  localparam logic [7:0] RstFirstHeader   = 8'd255;
  localparam logic [7:0] RstSecondHeader  = 8'd255;
  localparam logic [7:0] RstHighestId     = 8'd254;
  localparam logic [7:0] RstHighestStatus = 8'd130;
  localparam logic [5:0] RstLongestLength = 6'd33;

  localparam int unsigned IndexLimit = 31;
  localparam int unsigned LenOverhead = 2;
  localparam logic [5:0]  LenNoParams = 6'd2;
  localparam logic [5:0]  LenNextStep = 6'd3;

  typedef enum logic [1:0] {
    KIND_PARAM = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_BAD   = 2'd2
  } kind_e;

  typedef struct packed {
    logic load_id;
    logic load_len;
    logic load_status;
    logic load_param;
    logic rd_first;
    logic emit_param;
    logic emit_end;
    logic end_good;
  } ssfp_cmd_t;

  typedef struct packed {
    logic hdr1_hit;
    logic hdr2_hit;
    logic id_ok;
    logic len_ok;
    logic status_ok;
    logic has_params;
    logic params_done;
    logic sum_ok;
    logic last_param;
    logic out_free;
  } ssfp_status_t;

endpackage

/* rtl/ssfp_datapath.sv */
// Datapath: config registers, frame fields, checksum, parameter store, result register.
module ssfp_datapath import ssfp_pkg::*; #(
  parameter int unsigned MAX_PARAMS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [7:0]          rx_byte_i,
  input  ssfp_cmd_t           cmd_i,
  output ssfp_status_t        status_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [1:0]          kind_o,
  output logic [7:0]          servo_id_o,
  output logic [7:0]          status_byte_o,
  output logic [4:0]          param_index_o,
  output logic [7:0]          data_byte_o,
  output logic                last_o
);

  localparam int unsigned StoreCnt   = (MAX_PARAMS < IndexLimit) ? MAX_PARAMS : IndexLimit;
  localparam int unsigned AddrW      = (StoreCnt > 1) ? $clog2(StoreCnt) : 1;
  localparam int unsigned StoreDepth = 1 << AddrW;
  localparam logic [7:0]  LenCap     = 8'(StoreCnt + LenOverhead);

  logic [7:0] first_header_q, second_header_q, highest_id_q, highest_status_q;
  logic [5:0] longest_length_q;

  logic [7:0] frame_id_q, frame_status_q, sum_q;
  logic [5:0] frame_len_q;
  logic [4:0] seen_q, rd_idx_q, rd_next;

  logic [7:0] store_q [StoreDepth];
  logic [7:0] rdata_q;

  logic       out_valid_q, last_q;
  kind_e      kind_q;
  logic [7:0] id_out_q, status_out_q, data_q;
  logic [4:0] idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_header_q   <= RstFirstHeader;
      second_header_q  <= RstSecondHeader;
      highest_id_q     <= RstHighestId;
      highest_status_q <= RstHighestStatus;
      longest_length_q <= RstLongestLength;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FIRST_HEADER:   first_header_q   <= cfg_data_i;
        CFG_SECOND_HEADER:  second_header_q  <= cfg_data_i;
        CFG_HIGHEST_ID:     highest_id_q     <= cfg_data_i;
        CFG_HIGHEST_STATUS: highest_status_q <= cfg_data_i;
        CFG_LONGEST_LENGTH: longest_length_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_id_q     <= '0;
      frame_len_q    <= '0;
      frame_status_q <= '0;
      seen_q         <= '0;
      sum_q          <= '0;
      rd_idx_q       <= '0;
    end else begin
      if (cmd_i.load_id) begin
        frame_id_q <= rx_byte_i;
        sum_q      <= rx_byte_i;
      end else if (cmd_i.load_len) begin
        frame_len_q <= rx_byte_i[5:0];
        sum_q       <= sum_q + rx_byte_i;
      end else if (cmd_i.load_status) begin
        frame_status_q <= rx_byte_i;
        sum_q          <= sum_q + rx_byte_i;
        seen_q         <= '0;
      end else if (cmd_i.load_param) begin
        sum_q  <= sum_q + rx_byte_i;
        seen_q <= seen_q + 5'd1;
      end
      if (cmd_i.rd_first) begin
        rd_idx_q <= '0;
      end else if (cmd_i.emit_param) begin
        rd_idx_q <= rd_next;
      end
    end
  end

  assign rd_next = rd_idx_q + 5'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_param) begin
      store_q[seen_q[AddrW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd_first) begin
      rdata_q <= store_q[AddrW'(0)];
    end else if (cmd_i.emit_param) begin
      rdata_q <= store_q[rd_next[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_param || cmd_i.emit_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_param) begin
      kind_q       <= KIND_PARAM;
      id_out_q     <= frame_id_q;
      status_out_q <= frame_status_q;
      idx_q        <= rd_idx_q;
      data_q       <= rdata_q;
      last_q       <= 1'b0;
    end else if (cmd_i.emit_end) begin
      kind_q       <= cmd_i.end_good ? KIND_GOOD : KIND_BAD;
      id_out_q     <= frame_id_q;
      status_out_q <= frame_status_q;
      idx_q        <= '0;
      data_q       <= '0;
      last_q       <= 1'b1;
    end
  end

  always_comb begin
    status_o.hdr1_hit    = (rx_byte_i == first_header_q);
    status_o.hdr2_hit    = (rx_byte_i == second_header_q);
    status_o.id_ok       = (rx_byte_i <= highest_id_q);
    status_o.len_ok      = (rx_byte_i >= 8'(LenOverhead)) &&
                           (rx_byte_i <= {2'b00, longest_length_q}) &&
                           (rx_byte_i <= LenCap);
    status_o.status_ok   = (rx_byte_i <= highest_status_q);
    status_o.has_params  = (frame_len_q > LenNoParams);
    status_o.params_done = (({1'b0, seen_q} + LenNextStep) >= frame_len_q);
    status_o.sum_ok      = (rx_byte_i == ~sum_q);
    status_o.last_param  = (({1'b0, rd_idx_q} + LenNextStep) == frame_len_q);
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign servo_id_o    = id_out_q;
  assign status_byte_o = status_out_q;
  assign param_index_o = idx_q;
  assign data_byte_o   = data_q;
  assign last_o        = last_q;

endmodule

/* rtl/ssfp_ctrl.sv */
// Controller: frame parse state machine and result drain sequencing.
module ssfp_ctrl import ssfp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ssfp_status_t status_i,
  output ssfp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_HDR1,
    S_HDR2,
    S_ID,
    S_LEN,
    S_STATUS,
    S_PARAMS,
    S_CHECK,
    S_READ,
    S_DRAIN,
    S_END
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        end_good_q, end_good_d;
  logic        fire;

  always_comb begin
    case (state_q)
      S_HDR1, S_HDR2, S_ID, S_LEN, S_STATUS, S_PARAMS, S_CHECK: in_ready_o = 1'b1;
      default: in_ready_o = 1'b0;
    endcase
  end

  assign fire = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    end_good_d = end_good_q;
    cmd_o      = '0;
    cmd_o.end_good = end_good_q;
    case (state_q)
      S_HDR1: begin
        if (fire) state_d = status_i.hdr1_hit ? S_HDR2 : S_HDR1;
      end
      S_HDR2: begin
        if (fire) state_d = status_i.hdr2_hit ? S_ID : S_HDR1;
      end
      S_ID: begin
        if (fire) begin
          cmd_o.load_id = status_i.id_ok;
          state_d       = status_i.id_ok ? S_LEN : S_HDR1;
        end
      end
      S_LEN: begin
        if (fire) begin
          cmd_o.load_len = status_i.len_ok;
          state_d        = status_i.len_ok ? S_STATUS : S_HDR1;
        end
      end
      S_STATUS: begin
        if (fire) begin
          cmd_o.load_status = status_i.status_ok;
          if (!status_i.status_ok) state_d = S_HDR1;
          else if (status_i.has_params) state_d = S_PARAMS;
          else state_d = S_CHECK;
        end
      end
      S_PARAMS: begin
        if (fire) begin
          cmd_o.load_param = 1'b1;
          if (status_i.params_done) state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (fire) begin
          end_good_d = status_i.sum_ok;
          state_d    = (status_i.sum_ok && status_i.has_params) ? S_READ : S_END;
        end
      end
      S_READ: begin
        cmd_o.rd_first = 1'b1;
        state_d        = S_DRAIN;
      end
      S_DRAIN: begin
        if (status_i.out_free) begin
          cmd_o.emit_param = 1'b1;
          if (status_i.last_param) state_d = S_END;
        end
      end
      S_END: begin
        if (status_i.out_free) begin
          cmd_o.emit_end = 1'b1;
          state_d        = S_HDR1;
        end
      end
      default: state_d = S_HDR1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_HDR1;
      end_good_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      end_good_q <= end_good_d;
    end
  end

endmodule

/* rtl/servo_status_frame_parser_top.sv */
// Servo status frame parser: takes one received byte per transaction and reports frame results.
// Input is ready in every cycle while the parser hunts headers and collects a frame. After the
// checksum byte the input stalls while results go out through a single output register: a bad
// checksum, or a good frame without parameters, gives only the final result; a good frame with
// parameters first primes the single store read port with one read, then emits each parameter
// in order, then the final result. Each result waits while the consumer holds out_ready_i low.
// Failed header, id, length or status checks drop the frame silently and resume header hunting.
// Configuration writes take effect at the next clock edge.
module servo_status_frame_parser_top import ssfp_pkg::*; #(
  parameter int unsigned MAX_PARAMS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic [7:0]          servo_id_o,
  output logic [7:0]          status_byte_o,
  output logic [4:0]          param_index_o,
  output logic [7:0]          data_byte_o,
  output logic                last_o
);

  ssfp_cmd_t    cmd;
  ssfp_status_t status;

  ssfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ssfp_datapath #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .rx_byte_i     (rx_byte_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .kind_o        (kind_o),
    .servo_id_o    (servo_id_o),
    .status_byte_o (status_byte_o),
    .param_index_o (param_index_o),
    .data_byte_o   (data_byte_o),
    .last_o        (last_o)
  );

endmodule

/* rtl/ssfp_checker.sv */
// Port-level checker of the servo status frame parser and its bind.
module ssfp_checker import ssfp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [7:0] servo_id_o,
  input logic [7:0] status_byte_o,
  input logic [4:0] param_index_o,
  input logic [7:0] data_byte_o,
  input logic       last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(servo_id_o) &&
      $stable(status_byte_o) && $stable(param_index_o) && $stable(data_byte_o) &&
      $stable(last_o))
    else $error("result transaction changed while stalled");

  a_param_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_PARAM) |-> !last_o)
    else $error("parameter result flagged last");

  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_PARAM) |->
      last_o && (param_index_o == 5'd0) && (data_byte_o == 8'd0) &&
      ((kind_o == KIND_GOOD) || (kind_o == KIND_BAD)))
    else $error("malformed frame end result");

  a_drain_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_PARAM) |-> !in_ready_o)
    else $error("input taken while a frame drains");

endmodule

bind servo_status_frame_parser_top ssfp_checker u_ssfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .kind_o        (kind_o),
  .servo_id_o    (servo_id_o),
  .status_byte_o (status_byte_o),
  .param_index_o (param_index_o),
  .data_byte_o   (data_byte_o),
  .last_o        (last_o)
);

/* tb/sv/servo_status_frame_parser_top_tb.sv */
// Testbench for the servo status frame parser: directed and random frames against a parser model.
module servo_status_frame_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssfp_pkg::*;

  localparam int unsigned MaxParams        = 32;
  localparam int unsigned SettleCycles     = 40;
  localparam int unsigned StallLimit       = 2000;
  localparam int unsigned HoldOffCycles    = 300;
  localparam int unsigned RandomItems      = 40;
  localparam int unsigned MinRandomReports = 8;
  localparam int unsigned ReportLimit      = 10;
  localparam int unsigned ShortLength      = 10;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic [2:0] {
    PH_HDR1, PH_HDR2, PH_ID, PH_LEN, PH_STATUS, PH_PARAMS, PH_CHECK
  } parse_phase_e;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_ALT} fill_e;

  typedef enum int {SINK_OPEN, SINK_BUSY, SINK_CHOKED} sink_mode_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] servo_id;
    logic [7:0] status_byte;
    logic [4:0] param_index;
    logic [7:0] data_byte;
    logic       last;
  } report_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [7:0]          rx_byte_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [1:0]          kind_o;
  logic [7:0]          servo_id_o;
  logic [7:0]          status_byte_o;
  logic [4:0]          param_index_o;
  logic [7:0]          data_byte_o;
  logic                last_o;

  servo_status_frame_parser_top #(
    .MAX_PARAMS(MaxParams)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .servo_id_o   (servo_id_o),
    .status_byte_o(status_byte_o),
    .param_index_o(param_index_o),
    .data_byte_o  (data_byte_o),
    .last_o       (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [7:0]   hdr1_cfg       = RstFirstHeader;
  logic [7:0]   hdr2_cfg       = RstSecondHeader;
  logic [7:0]   max_id_cfg     = RstHighestId;
  logic [7:0]   max_status_cfg = RstHighestStatus;
  logic [5:0]   max_len_cfg    = RstLongestLength;
  parse_phase_e phase          = PH_HDR1;
  logic [7:0]   cur_id         = '0;
  logic [5:0]   cur_len        = '0;
  logic [7:0]   cur_status     = '0;
  logic [4:0]   params_seen    = '0;
  logic [7:0]   frame_sum      = '0;
  logic [7:0]   param_buf [MaxParams];
  report_t      report_q [$];

  int bytes_sent      = 0;
  int reports_checked = 0;
  int good_frames     = 0;
  int bad_frames      = 0;
  int param_reports   = 0;
  int settings_used   = 0;
  int failures        = 0;
  int burst_left      = 0;
  int idle_cycles     = 0;
  int hold_left       = 0;
  int mode_left       = 0;
  bit hold_request    = 1'b0;
  sink_mode_e sink_mode = SINK_OPEN;
  report_t seen_report;
  report_t due_report;

  function automatic void parse_rx_byte(input logic [7:0] b);
    int      n_params;
    report_t r;
    case (phase)
      PH_HDR1: phase = (b == hdr1_cfg) ? PH_HDR2 : PH_HDR1;
      PH_HDR2: phase = (b == hdr2_cfg) ? PH_ID : PH_HDR1;
      PH_ID: begin
        if (b <= max_id_cfg) begin
          cur_id    = b;
          frame_sum = b;
          phase     = PH_LEN;
        end else begin
          phase = PH_HDR1;
        end
      end
      PH_LEN: begin
        if (b >= LenOverhead && b <= max_len_cfg && b - LenOverhead <= MaxParams &&
            b - LenOverhead <= IndexLimit) begin
          cur_len   = b[5:0];
          frame_sum = frame_sum + b;
          phase     = PH_STATUS;
        end else begin
          phase = PH_HDR1;
        end
      end
      PH_STATUS: begin
        if (b <= max_status_cfg) begin
          cur_status  = b;
          frame_sum   = frame_sum + b;
          params_seen = '0;
          phase       = (cur_len > LenNoParams) ? PH_PARAMS : PH_CHECK;
        end else begin
          phase = PH_HDR1;
        end
      end
      PH_PARAMS: begin
        param_buf[params_seen] = b;
        frame_sum   = frame_sum + b;
        params_seen = params_seen + 5'd1;
        if (int'(params_seen) + LenOverhead >= cur_len) phase = PH_CHECK;
      end
      PH_CHECK: begin
        if (b == ~frame_sum) begin
          n_params = int'(cur_len) - int'(LenOverhead);
          for (int i = 0; i < n_params && i < MaxParams && i <= IndexLimit; i++) begin
            r = '{kind: KIND_PARAM, servo_id: cur_id, status_byte: cur_status,
                  param_index: 5'(i), data_byte: param_buf[i], last: 1'b0};
            report_q.push_back(r);
            param_reports++;
          end
          r = '{kind: KIND_GOOD, servo_id: cur_id, status_byte: cur_status,
                param_index: 5'd0, data_byte: 8'd0, last: 1'b1};
          good_frames++;
        end else begin
          r = '{kind: KIND_BAD, servo_id: cur_id, status_byte: cur_status,
                param_index: 5'd0, data_byte: 8'd0, last: 1'b1};
          bad_frames++;
        end
        report_q.push_back(r);
        phase = PH_HDR1;
      end
      default: phase = PH_HDR1;
    endcase
  endfunction

  function automatic void set_model_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    case (idx)
      CFG_FIRST_HEADER:   hdr1_cfg       = val;
      CFG_SECOND_HEADER:  hdr2_cfg       = val;
      CFG_HIGHEST_ID:     max_id_cfg     = val;
      CFG_HIGHEST_STATUS: max_status_cfg = val;
      CFG_LONGEST_LENGTH: max_len_cfg    = val[5:0];
      default: ;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    set_model_reg(idx, val);
  endtask

  task automatic apply_config(input logic [7:0] h1, input logic [7:0] h2, input logic [7:0] mid,
                              input logic [7:0] mst, input logic [5:0] mlen);
    wait_drained();
    write_reg(CFG_FIRST_HEADER, h1);
    write_reg(CFG_SECOND_HEADER, h2);
    write_reg(CFG_HIGHEST_ID, mid);
    write_reg(CFG_HIGHEST_STATUS, mst);
    write_reg(CFG_LONGEST_LENGTH, {2'b00, mlen});
    settings_used++;
  endtask

  task automatic send_frame(input logic [7:0] id, input logic [7:0] len, input logic [7:0] status,
                            input fill_e fill, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] p;
    send_byte(hdr1_cfg);
    send_byte(hdr2_cfg);
    send_byte(id);
    send_byte(len);
    send_byte(status);
    sum = id + len + status;
    for (int i = 0; i + LenOverhead < len; i++) begin
      case (fill)
        FILL_ZERO: p = 8'h00;
        FILL_ONES: p = 8'hFF;
        FILL_ALT:  p = (i % 2 == 0) ? 8'hAA : 8'h55;
        default:   p = 8'($urandom);
      endcase
      sum = sum + p;
      send_byte(p);
    end
    send_byte(bad_sum ? (~sum ^ 8'($urandom_range(1, 255))) : ~sum);
  endtask

  // headers, then id, length and status up to the field that breaks the frame
  task automatic send_prefix(input logic [7:0] id, input logic [7:0] len,
                             input logic [7:0] status, input int upto);
    send_byte(hdr1_cfg);
    send_byte(hdr2_cfg);
    if (upto >= 3) send_byte(id);
    if (upto >= 4) send_byte(len);
    if (upto >= 5) send_byte(status);
  endtask

  task automatic random_config();
    logic [7:0] h1;
    logic [7:0] h2;
    logic [7:0] mid;
    logic [7:0] mst;
    logic [5:0] mlen;
    h1 = 8'($urandom);
    h2 = ($urandom_range(0, 3) == 0) ? h1 : 8'($urandom);
    case ($urandom_range(0, 5))
      0:       mid = 8'h00;
      1:       mid = 8'hFF;
      default: mid = 8'($urandom_range(16, 255));
    endcase
    case ($urandom_range(0, 5))
      0:       mst = 8'h00;
      1:       mst = 8'hFF;
      default: mst = 8'($urandom_range(16, 255));
    endcase
    case ($urandom_range(0, 5))
      0:       mlen = LenNoParams;
      1:       mlen = 6'(IndexLimit + LenOverhead);
      default: mlen = 6'($urandom_range(LenOverhead, IndexLimit + LenOverhead));
    endcase
    apply_config(h1, h2, mid, mst, mlen);
  endtask

  task automatic random_frame();
    int         pick;
    int         lim;
    int         short_lim;
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] st;
    logic [7:0] b;
    lim       = (max_len_cfg > IndexLimit + LenOverhead) ? IndexLimit + LenOverhead : max_len_cfg;
    short_lim = (lim < ShortLength) ? lim : ShortLength;
    id        = 8'($urandom_range(0, max_id_cfg));
    st        = 8'($urandom_range(0, max_status_cfg));
    len       = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(LenOverhead, lim)) :
                                              8'($urandom_range(LenOverhead, short_lim));
    pick      = $urandom_range(0, 99);
    if (pick < 62) begin
      send_frame(id, len, st, FILL_RANDOM, 1'b0);
    end else if (pick < 77) begin
      send_frame(id, len, st, FILL_RANDOM, 1'b1);
    end else if (pick < 83 && max_id_cfg != 8'hFF) begin
      send_prefix(8'($urandom_range(max_id_cfg + 1, 255)), len, st, 3);
    end else if (pick < 88) begin
      len = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(lim + 1, 255));
      send_prefix(id, len, st, 4);
    end else if (pick < 93 && max_status_cfg != 8'hFF) begin
      send_prefix(id, len, 8'($urandom_range(max_status_cfg + 1, 255)), 5);
    end else if (pick < 96) begin
      send_byte(hdr1_cfg);
      do b = 8'($urandom); while (b == hdr2_cfg);
      if (hdr1_cfg != hdr2_cfg && $urandom_range(0, 1) == 1) b = hdr1_cfg;
      send_byte(b);
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end
  endtask

  task automatic test_reset_defaults();
    send_frame(8'd0, {2'b00, LenNoParams}, 8'd0, FILL_ZERO, 1'b0);
    send_frame(RstHighestId, {2'b00, LenNextStep}, RstHighestStatus, FILL_ONES, 1'b0);
    send_frame(8'h81, {2'b00, LenNoParams}, 8'h42, FILL_ZERO, 1'b1);
    send_prefix(8'hFF, 8'd0, 8'd0, 3);
    send_prefix(8'd1, 8'd0, 8'd0, 4);
    send_prefix(8'd1, 8'd1, 8'd0, 4);
    send_prefix(8'd1, 8'd34, 8'd0, 4);
    send_prefix(8'd1, {2'b00, LenNoParams}, RstHighestStatus + 8'd1, 5);
    send_byte(RstFirstHeader);
    send_byte(8'h00);
    send_frame(8'd7, 8'd5, 8'h0F, FILL_ALT, 1'b0);
    wait_drained();
  endtask

  task automatic test_limit_extremes();
    apply_config(8'h00, 8'h00, 8'h00, 8'h00, LenNoParams);
    send_frame(8'd0, {2'b00, LenNoParams}, 8'd0, FILL_ZERO, 1'b0);
    send_frame(8'd0, {2'b00, LenNoParams}, 8'd0, FILL_ZERO, 1'b1);
    send_prefix(8'd0, {2'b00, LenNextStep}, 8'd0, 4);
    send_prefix(8'd1, {2'b00, LenNoParams}, 8'd0, 3);
    send_prefix(8'd0, {2'b00, LenNoParams}, 8'd1, 5);
    apply_config(8'hAA, 8'h55, 8'hFF, 8'hFF, 6'(IndexLimit + LenOverhead));
    send_frame(8'hFF, 8'(IndexLimit + LenOverhead), 8'hFF, FILL_ALT, 1'b0);
    send_byte(8'hAA);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_frame(8'h3C, 8'd4, 8'hC3, FILL_RANDOM, 1'b0);
    wait_drained();
    write_reg(CFG_SPARE_LO, 8'h12);
    write_reg(CFG_SPARE_HI, 8'hFF);
    send_frame(8'h10, 8'd6, 8'h01, FILL_RANDOM, 1'b0);
    apply_config(8'h5A, 8'hA5, 8'd100, 8'd64, 6'd17);
    send_frame(8'd100, 8'd17, 8'd64, FILL_RANDOM, 1'b0);
    send_prefix(8'd0, 8'd18, 8'd0, 4);
    send_prefix(8'd101, {2'b00, LenNoParams}, 8'd0, 3);
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    apply_config(RstFirstHeader, RstSecondHeader, RstHighestId, RstHighestStatus,
                 RstLongestLength);
    hold_request = 1'b1;
    repeat (2) send_frame(8'($urandom_range(0, max_id_cfg)), 8'd20,
                          8'($urandom_range(0, max_status_cfg)), FILL_RANDOM, 1'b0);
    wait_drained();
    send_frame(8'd9, 8'd8, 8'd3, FILL_RANDOM, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int start_bytes;
    int start_reports;
    int frames;
    start_bytes   = bytes_sent;
    start_reports = reports_checked;
    frames        = 0;
    while (bytes_sent - start_bytes < RandomItems ||
           reports_checked - start_reports < MinRandomReports) begin
      if (frames % 8 == 0) random_config();
      random_frame();
      frames++;
    end
    wait_drained();
  endtask

  task automatic log_failure(input string what, input report_t want, input report_t got);
    failures++;
    if (failures <= ReportLimit) begin
      $display("%0t %s: expected kind=%0d id=%h status=%h index=%0d data=%h last=%b",
               $realtime, what, want.kind, want.servo_id, want.status_byte, want.param_index,
               want.data_byte, want.last);
      $display("%0t %s: actual   kind=%0d id=%h status=%h index=%0d data=%h last=%b",
               $realtime, what, got.kind, got.servo_id, got.status_byte, got.param_index,
               got.data_byte, got.last);
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HoldOffCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (sink_mode)
        SINK_OPEN: out_ready_i <= 1'b1;
        SINK_BUSY: out_ready_i <= ($urandom_range(0, 3) != 0);
        default:   out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_report = '{kind: kind_e'(kind_o), servo_id: servo_id_o, status_byte: status_byte_o,
                      param_index: param_index_o, data_byte: data_byte_o, last: last_o};
      if (report_q.size() == 0) begin
        log_failure("unexpected report", '0, seen_report);
      end else begin
        due_report = report_q.pop_front();
        reports_checked++;
        if (seen_report.kind !== due_report.kind ||
            seen_report.servo_id !== due_report.servo_id ||
            seen_report.status_byte !== due_report.status_byte ||
            seen_report.param_index !== due_report.param_index ||
            seen_report.data_byte !== due_report.data_byte ||
            seen_report.last !== due_report.last) begin
          log_failure("report mismatch", due_report, seen_report);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (!in_valid_i && report_q.size() == 0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("Timeout: no transaction for %0d cycles, %0d reports pending",
                 idle_cycles, report_q.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_limit_extremes();
    test_output_backpressure();
    test_random_traffic();
    $display("Run covered %0d bytes over %0d register settings: %0d good frames,",
             bytes_sent, settings_used, good_frames);
    $display("%0d bad checksums, %0d parameter reports, %0d reports checked, %0d failures",
             bad_frames, param_reports, reports_checked, failures);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ssfp_pkg.sv
rtl/ssfp_datapath.sv
rtl/ssfp_ctrl.sv
rtl/servo_status_frame_parser_top.sv
rtl/ssfp_checker.sv
tb/sv/servo_status_frame_parser_top_tb.sv
